// File: src/ucif_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucif_pkg
// Types and constants shared by the configuration descriptor walker.
// ----------------------------------------------------------------------------
package ucif_pkg;

  // result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // descriptor type codes
  localparam logic [7:0] DT_INTERFACE = 8'd4;
  localparam logic [7:0] DT_ENDPOINT  = 8'd5;

  // endpoint descriptor fields
  localparam int unsigned EP_DIR_IN_BIT = 7;
  localparam logic [1:0]  XFER_BULK     = 2'd2;

  // minimum descriptor lengths
  localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
  localparam logic [7:0] EP_MIN_LEN    = 8'd7;
  localparam logic [7:0] MIN_DESC_LEN  = 8'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ALT_SETTING = 2'd0;
  localparam logic [1:0] REG_CLASS       = 2'd1;
  localparam logic [1:0] REG_SUBCLASS    = 2'd2;
  localparam logic [1:0] REG_PROTOCOL    = 2'd3;

  // configuration register reset values
  localparam logic [7:0] RST_ALT_SETTING = 8'h00;
  localparam logic [7:0] RST_CLASS       = 8'hff;
  localparam logic [7:0] RST_SUBCLASS    = 8'hfe;
  localparam logic [7:0] RST_PROTOCOL    = 8'h02;

  typedef struct packed {
    logic [7:0] alt_setting;
    logic [7:0] class_code;
    logic [7:0] subclass;
    logic [7:0] protocol;
  } ucif_match_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] interface_number;
    logic [7:0] in_endpoint;
    logic [7:0] out_endpoint;
  } ucif_result_t;

endpackage
`default_nettype wire

// File: src/ucif_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucif_parser
// Per-byte descriptor walker: tracks position in the current descriptor,
// captures interface and endpoint fields and decides the result.
// ----------------------------------------------------------------------------
module ucif_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  input  wire ucif_pkg::ucif_match_t match_cfg,
  output logic                       res_valid,
  output ucif_pkg::ucif_result_t     res
);
  import ucif_pkg::*;

  logic [7:0] byte_pos, byte_pos_next;
  logic [7:0] desc_len, desc_len_next;
  logic [7:0] desc_type, desc_type_next;
  logic [7:0] cap [5];
  logic [7:0] cap_next [5];
  logic       iface_sel, iface_sel_next;
  logic [7:0] found_if, found_if_next;
  logic [7:0] found_in, found_in_next;
  logic [7:0] found_out, found_out_next;
  logic       result_given, result_given_next;

  logic       desc_done;
  logic       is_iface;
  logic       is_bulk_ep;
  logic       iface_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos     <= '0;
      desc_len     <= '0;
      desc_type    <= '0;
      for (int i = 0; i < 5; i++) cap[i] <= '0;
      iface_sel    <= 1'b0;
      found_if     <= '0;
      found_in     <= '0;
      found_out    <= '0;
      result_given <= 1'b0;
    end else begin
      byte_pos     <= byte_pos_next;
      desc_len     <= desc_len_next;
      desc_type    <= desc_type_next;
      for (int i = 0; i < 5; i++) cap[i] <= cap_next[i];
      iface_sel    <= iface_sel_next;
      found_if     <= found_if_next;
      found_in     <= found_in_next;
      found_out    <= found_out_next;
      result_given <= result_given_next;
    end
  end

  always_comb begin
    byte_pos_next     = byte_pos;
    desc_len_next     = desc_len;
    desc_type_next    = desc_type;
    for (int i = 0; i < 5; i++) cap_next[i] = cap[i];
    iface_sel_next    = iface_sel;
    found_if_next     = found_if;
    found_in_next     = found_in;
    found_out_next    = found_out;
    result_given_next = result_given;
    res_valid         = 1'b0;
    res               = '0;
    desc_done         = 1'b0;
    is_iface          = 1'b0;
    is_bulk_ep        = 1'b0;
    iface_match       = 1'b0;

    if (accept && !result_given) begin
      if (byte_pos == 8'd0) begin
        desc_len_next = data_byte;
        if (last_byte) begin
          // lone trailing byte
          res_valid  = 1'b1;
          res.status = ST_NOT_FOUND;
        end else if (data_byte < MIN_DESC_LEN) begin
          res_valid         = 1'b1;
          res.status        = ST_MALFORMED;
          result_given_next = 1'b1;
        end else begin
          byte_pos_next = 8'd1;
        end
      end else begin
        case (byte_pos)
          8'd1:    desc_type_next = data_byte;
          8'd2:    cap_next[0]    = data_byte;
          8'd3:    cap_next[1]    = data_byte;
          8'd5:    cap_next[2]    = data_byte;
          8'd6:    cap_next[3]    = data_byte;
          8'd7:    cap_next[4]    = data_byte;
          default: ;
        endcase

        desc_done  = ({1'b0, byte_pos} + 9'd1) >= {1'b0, desc_len};
        is_iface   = (desc_type_next == DT_INTERFACE) && (desc_len >= IFACE_MIN_LEN);
        is_bulk_ep = iface_sel && (desc_type_next == DT_ENDPOINT) &&
                     (desc_len >= EP_MIN_LEN) && (cap_next[1][1:0] == XFER_BULK);
        iface_match = (cap_next[1] == match_cfg.alt_setting) &&
                      (cap_next[2] == match_cfg.class_code) &&
                      (cap_next[3] == match_cfg.subclass) &&
                      (cap_next[4] == match_cfg.protocol);

        if (desc_done) begin
          byte_pos_next = 8'd0;
          if (is_iface) begin
            iface_sel_next = iface_match;
            if (iface_match) begin
              found_if_next  = cap_next[0];
              found_in_next  = '0;
              found_out_next = '0;
            end
          end else if (is_bulk_ep) begin
            if (cap_next[0][EP_DIR_IN_BIT]) found_in_next = cap_next[0];
            else                            found_out_next = cap_next[0];
          end

          if (is_bulk_ep && !is_iface && found_in_next != 8'd0 &&
              found_out_next != 8'd0) begin
            res_valid            = 1'b1;
            res.status           = ST_FOUND;
            res.interface_number = found_if_next;
            res.in_endpoint      = found_in_next;
            res.out_endpoint     = found_out_next;
            result_given_next    = 1'b1;
          end else if (last_byte) begin
            res_valid  = 1'b1;
            res.status = ST_NOT_FOUND;
          end
        end else if (last_byte) begin
          // descriptor cut off by the end of the set
          res_valid  = 1'b1;
          res.status = ST_MALFORMED;
        end else begin
          byte_pos_next = byte_pos + 8'd1;
        end
      end
    end

    // final byte always starts the next set from scratch
    if (accept && last_byte) begin
      byte_pos_next     = '0;
      desc_len_next     = '0;
      desc_type_next    = '0;
      for (int i = 0; i < 5; i++) cap_next[i] = '0;
      iface_sel_next    = 1'b0;
      found_if_next     = '0;
      found_in_next     = '0;
      found_out_next    = '0;
      result_given_next = 1'b0;
    end
  end

  a_quiet_after_result: assert property (@(posedge clk) disable iff (rst)
    (accept && result_given) |-> !res_valid)
    else $error("request produced a result after one was already given");

  a_found_has_both: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_FOUND) |->
      (res.in_endpoint != 8'd0 && res.out_endpoint != 8'd0 && res.in_endpoint[7]))
    else $error("found result without both endpoints");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (byte_pos == 8'd0 && !result_given && !iface_sel))
    else $error("parser not cleared after final byte");

endmodule
`default_nettype wire

// File: src/ucif_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucif_out_buf
// Output register plus one skid entry so the input side keeps flowing while
// a result waits on the output.
// ----------------------------------------------------------------------------
module ucif_out_buf (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire ucif_pkg::ucif_result_t push_data,
  output logic                        full,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output ucif_pkg::ucif_result_t      out_data
);
  import ucif_pkg::*;

  logic         skid_valid;
  ucif_result_t skid_data;
  logic         pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid)  out_data <= skid_data;
      else if (push)   out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("result pushed into a full output buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (out_valid && !skid_valid))
    else $error("skid entry not promoted after output pop");

endmodule
`default_nettype wire

// File: src/usb_config_interface_finder.sv
`default_nettype none
// A result is registered in the output buffer, and waits in its skid entry while the output is stalled.
// Throughput: one descriptor byte per cycle while in_stall is low; the per-byte
// parse step is a set of compares and a counter update between registers.
// in_stall rises only while both the output register and its skid entry hold results.
// Reset (rst, synchronous): parser cleared, output empty, match registers
// return to alt 0, class 0xff, subclass 0xfe, protocol 0x02.
// ----------------------------------------------------------------------------
// usb_config_interface_finder
// Finds the matching interface in a configuration descriptor set and reports
// its bulk IN and OUT endpoint addresses.
// ----------------------------------------------------------------------------
module usb_config_interface_finder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [7:0]      interface_number,
  output logic [7:0]      in_endpoint,
  output logic [7:0]      out_endpoint
);
  import ucif_pkg::*;

  ucif_match_t  match_cfg;
  ucif_result_t res;
  ucif_result_t out_data;
  logic         res_valid;
  logic         accept;
  logic         buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_cfg.alt_setting <= RST_ALT_SETTING;
      match_cfg.class_code  <= RST_CLASS;
      match_cfg.subclass    <= RST_SUBCLASS;
      match_cfg.protocol    <= RST_PROTOCOL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALT_SETTING: match_cfg.alt_setting <= cfg_data;
        REG_CLASS:       match_cfg.class_code  <= cfg_data;
        REG_SUBCLASS:    match_cfg.subclass    <= cfg_data;
        REG_PROTOCOL:    match_cfg.protocol    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  ucif_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .match_cfg (match_cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ucif_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign status           = out_data.status;
  assign interface_number = out_data.interface_number;
  assign in_endpoint      = out_data.in_endpoint;
  assign out_endpoint     = out_data.out_endpoint;

  a_no_result_without_request: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> accept)
    else $error("result produced without an accepted request");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_FOUND || status == ST_NOT_FOUND || status == ST_MALFORMED))
    else $error("illegal status code on output");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule
`default_nettype wire

// File: verif/ucif_result_checker.sv
// ----------------------------------------------------------------------------
// ucif_result_checker
// Follows the byte and result channels of the interface finder. Each accepted
// byte goes through a local descriptor walker, and every accepted result is
// compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ucif_result_checker
  import ucif_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] status,
  input  wire logic [7:0] interface_number,
  input  wire logic [7:0] in_endpoint,
  input  wire logic [7:0] out_endpoint,
  output int unsigned     fail_count,
  output int unsigned     outstanding
);

  ucif_match_t    want;
  logic [7:0]     pos;
  logic [7:0]     dlen;
  logic [7:0]     dtype;
  logic [7:0]     fld [5];
  logic           selected;
  logic [7:0]     iface_num;
  logic [7:0]     ep_in;
  logic [7:0]     ep_out;
  logic           done;

  ucif_result_t   due_results [$];
  int unsigned    errors = 0;
  int unsigned    backlog = 0;

  assign fail_count  = errors;
  assign outstanding = backlog;

  task automatic clear_walker();
    pos       = '0;
    dlen      = '0;
    dtype     = '0;
    foreach (fld[i]) fld[i] = '0;
    selected  = 1'b0;
    iface_num = '0;
    ep_in     = '0;
    ep_out    = '0;
    done      = 1'b0;
  endtask

  // acts on a complete descriptor; complete is set once both endpoints are known
  task automatic close_descriptor(output logic complete);
    complete = 1'b0;
    if (dtype == DT_INTERFACE && dlen >= IFACE_MIN_LEN) begin
      selected = fld[1] == want.alt_setting && fld[2] == want.class_code &&
                 fld[3] == want.subclass && fld[4] == want.protocol;
      if (selected) begin
        iface_num = fld[0];
        ep_in     = '0;
        ep_out    = '0;
      end
    end else if (selected && dtype == DT_ENDPOINT && dlen >= EP_MIN_LEN &&
                 fld[1][1:0] == XFER_BULK) begin
      if (fld[0][EP_DIR_IN_BIT]) ep_in = fld[0];
      else ep_out = fld[0];
      complete = ep_in != '0 && ep_out != '0;
    end
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic fin, output logic hit,
                           output ucif_result_t r);
    logic [7:0] p;
    logic       complete;
    hit = 1'b0;
    r   = '0;
    p   = pos;
    if (done) begin
      // bytes after a result are dropped until the end of the set
      if (fin) clear_walker();
    end else if (p == '0) begin
      dlen = b;
      if (fin) begin
        hit      = 1'b1;
        r.status = ST_NOT_FOUND;
      end else if (b < MIN_DESC_LEN) begin
        hit      = 1'b1;
        r.status = ST_MALFORMED;
        done     = 1'b1;
      end else begin
        pos = 8'd1;
      end
      if (fin) clear_walker();
    end else begin
      case (p)
        8'd1: dtype = b;
        8'd2: fld[0] = b;
        8'd3: fld[1] = b;
        8'd5: fld[2] = b;
        8'd6: fld[3] = b;
        8'd7: fld[4] = b;
        default: ;
      endcase
      if ({1'b0, p} + 9'd1 >= {1'b0, dlen}) begin
        close_descriptor(complete);
        if (complete) begin
          hit  = 1'b1;
          r    = {ST_FOUND, iface_num, ep_in, ep_out};
          done = 1'b1;
        end else if (fin) begin
          hit      = 1'b1;
          r.status = ST_NOT_FOUND;
        end
        pos = '0;
      end else if (fin) begin
        hit      = 1'b1;
        r.status = ST_MALFORMED;
      end else begin
        pos = p + 8'd1;
      end
      if (fin) clear_walker();
    end
  endtask

  // values shown as status/iface/in/out
  task automatic note_failure(input string what, input ucif_result_t exp_r,
                              input ucif_result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected %0d/%h/%h/%h, got %0d/%h/%h/%h",
               $time, what, exp_r.status, exp_r.interface_number, exp_r.in_endpoint,
               exp_r.out_endpoint, got.status, got.interface_number, got.in_endpoint,
               got.out_endpoint);
  endtask

  always @(posedge clk) begin
    ucif_result_t got;
    ucif_result_t exp_r;
    ucif_result_t r;
    logic         hit;
    if (rst) begin
      want = {RST_ALT_SETTING, RST_CLASS, RST_SUBCLASS, RST_PROTOCOL};
      clear_walker();
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {status, interface_number, in_endpoint, out_endpoint};
        if (due_results.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          exp_r = due_results.pop_front();
          if (got.status !== exp_r.status ||
              got.interface_number !== exp_r.interface_number ||
              got.in_endpoint !== exp_r.in_endpoint ||
              got.out_endpoint !== exp_r.out_endpoint)
            note_failure("result mismatch", exp_r, got);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ALT_SETTING: want.alt_setting = cfg_data;
          REG_CLASS:       want.class_code  = cfg_data;
          REG_SUBCLASS:    want.subclass    = cfg_data;
          REG_PROTOCOL:    want.protocol    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        walk_byte(data_byte, last_byte, hit, r);
        if (hit) due_results.push_back(r);
      end
    end
    backlog <= due_results.size();
  end

endmodule

// File: verif/usb_config_interface_finder_test.sv
// ----------------------------------------------------------------------------
// usb_config_interface_finder_test
// Streams directed and random configuration descriptor sets through the
// interface finder under several match settings, with random gaps and output
// stalls; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module usb_config_interface_finder_test;
  import ucif_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_BYTES  = 240;
  localparam int unsigned PHASE_SETS   = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = '0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] interface_number;
  logic [7:0] in_endpoint;
  logic [7:0] out_endpoint;

  int unsigned fail_count;
  int unsigned outstanding;

  ucif_match_t target = {RST_ALT_SETTING, RST_CLASS, RST_SUBCLASS, RST_PROTOCOL};
  logic [7:0]  set_q [$];
  logic        calm = 1'b0;
  int unsigned sent_count = 0;
  int unsigned set_count = 0;
  int unsigned hold_cnt = 0;
  int unsigned cycle_count = 0;

  usb_config_interface_finder dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .data_byte, .last_byte,
    .out_valid, .out_stall, .status, .interface_number, .in_endpoint, .out_endpoint
  );

  ucif_result_checker result_chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .data_byte, .last_byte,
    .out_valid, .out_stall, .status, .interface_number, .in_endpoint, .out_endpoint,
    .fail_count, .outstanding
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 2) == 0);
      hold_cnt  <= pick_gap();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_count++;
  endtask

  task automatic send_set();
    foreach (set_q[i]) send_byte(set_q[i], i == set_q.size() - 1);
    set_count++;
  endtask

  // one descriptor: length, type, then body bytes from offset 2, random past offset 8
  task automatic put_desc(input logic [7:0] len, input logic [7:0] kind,
                          input logic [55:0] body);
    set_q.push_back(len);
    set_q.push_back(kind);
    for (int k = 2; k < len; k++)
      set_q.push_back(k < 9 ? body[8*(k-2) +: 8] : 8'($urandom));
  endtask

  task automatic put_iface(input logic hit);
    ucif_match_t m;
    logic [7:0]  len;
    int unsigned r;
    m = target;
    if (!hit) begin
      // near miss: one bit off in one field
      case ($urandom_range(0, 3))
        0: m.alt_setting ^= 8'(1 << $urandom_range(0, 7));
        1: m.class_code  ^= 8'(1 << $urandom_range(0, 7));
        2: m.subclass    ^= 8'(1 << $urandom_range(0, 7));
        default: m.protocol ^= 8'(1 << $urandom_range(0, 7));
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 80) len = IFACE_MIN_LEN;
    else if (r < 92) len = 8'($urandom_range(10, 12));
    else len = 8'($urandom_range(2, 8));
    put_desc(len, DT_INTERFACE, {8'($urandom), m.protocol, m.subclass, m.class_code,
                                 8'($urandom_range(0, 3)), m.alt_setting, 8'($urandom)});
  endtask

  task automatic put_endpoint();
    logic [7:0]  addr;
    logic [7:0]  attr;
    logic [7:0]  len;
    int unsigned r;
    addr = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45) addr[EP_DIR_IN_BIT] = 1'b1;
    else if (r < 90) addr[EP_DIR_IN_BIT] = 1'b0;
    else addr = '0;
    attr = 8'($urandom);
    if ($urandom_range(0, 3) != 0) attr[1:0] = XFER_BULK;
    r = $urandom_range(0, 99);
    if (r < 85) len = EP_MIN_LEN;
    else if (r < 95) len = 8'($urandom_range(8, 9));
    else len = 8'($urandom_range(2, 6));
    put_desc(len, DT_ENDPOINT, {8'($urandom), 8'($urandom), 8'($urandom_range(0, 16)),
                                8'($urandom), 8'($urandom), attr, addr});
  endtask

  task automatic build_good_set();
    set_q.delete();
    if ($urandom_range(0, 1) != 0) put_desc(8'd9, 8'h02, 56'({$urandom, $urandom}));
    repeat ($urandom_range(1, 2)) begin
      put_iface($urandom_range(0, 99) < 60);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 9) == 0)
          put_desc(8'($urandom_range(2, 6)), 8'h24, 56'({$urandom, $urandom}));
        else
          put_endpoint();
      end
    end
  endtask

  task automatic build_noise_set();
    set_q.delete();
    repeat ($urandom_range(1, 12)) set_q.push_back(8'($urandom));
    if ($urandom_range(0, 1) != 0) set_q[0] = 8'($urandom_range(0, 3));
  endtask

  task automatic write_match(input ucif_match_t m);
    cfg_write <= 1'b1;
    cfg_index <= REG_ALT_SETTING;
    cfg_data  <= m.alt_setting;
    @(posedge clk);
    cfg_index <= REG_CLASS;
    cfg_data  <= m.class_code;
    @(posedge clk);
    cfg_index <= REG_SUBCLASS;
    cfg_data  <= m.subclass;
    @(posedge clk);
    cfg_index <= REG_PROTOCOL;
    cfg_data  <= m.protocol;
    @(posedge clk);
    cfg_write <= 1'b0;
    target = m;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    ucif_match_t m;
    int unsigned r;
    int unsigned base_bytes;
    int unsigned base_sets;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // final byte alone in its set
    set_q = '{8'hff};
    send_set();
    // zero length, trailing byte dropped
    set_q = '{8'h00, 8'h00};
    send_set();
    // length one, then dropped bytes
    set_q = '{8'h01, 8'hff, 8'h5a};
    send_set();
    // set ends inside a descriptor
    set_q = '{8'h05, 8'h24, 8'h00};
    send_set();
    // one complete descriptor, no interface
    set_q = '{8'h02, 8'h24};
    send_set();
    // matching interface with bulk IN then bulk OUT, then an ignored byte
    set_q = '{8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hff, 8'hfe, 8'h02, 8'h00,
              8'h07, 8'h05, 8'h81, 8'h02, 8'h00, 8'h02, 8'h00,
              8'h07, 8'h05, 8'h01, 8'h02, 8'h00, 8'h02, 8'h00,
              8'h09};
    send_set();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_idle();
        case (phase)
          1: m = '0;
          2: m = '1;
          3: m = {8'h55, 8'haa, 8'h55, 8'haa};
          default: m = ucif_match_t'($urandom);
        endcase
        write_match(m);
      end
      base_bytes = sent_count;
      base_sets  = set_count;
      while (sent_count - base_bytes < PHASE_BYTES || set_count - base_sets < PHASE_SETS) begin
        calm <= ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          build_good_set();
        end else if (r < 85) begin
          // well-formed set cut short
          build_good_set();
          if (set_q.size() > 1)
            repeat ($urandom_range(1, set_q.size() - 1)) void'(set_q.pop_back());
        end else begin
          build_noise_set();
        end
        send_set();
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
